// ===== rtl/core/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

  // Address and frame geometry.
  localparam int ADDR_W      = 32;
  localparam int FRAME_SHIFT = 12;
  localparam int IDX_W       = ADDR_W - FRAME_SHIFT;

  // Used/free bitmap: one bit per frame, held as 64-bit words.
  localparam int MAP_FRAMES = 1048576;
  localparam int MAP_IDX_W  = $clog2(MAP_FRAMES);
  localparam int WORD_BITS  = 64;
  localparam int WSEL_W     = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = MAP_FRAMES / WORD_BITS;
  localparam int MWADDR_W   = MAP_IDX_W - WSEL_W;

  // Prefetched allocation batch.
  localparam int BATCH  = 20;
  localparam int POS_W  = $clog2(BATCH + 1);
  localparam int BIDX_W = (BATCH > 1) ? $clog2(BATCH) : 1;

  // Frame count register.
  localparam int CNT_W     = 21;
  localparam int CNT_RESET = 1048576;

  // Stream widths.
  localparam int S_DATA_W = 2 * ADDR_W;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = ADDR_W;
  localparam int M_USER_W = 1;

  typedef enum logic [1:0] {
    MODE_USED  = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_ALLOC = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RANGE_RD,
    ST_RANGE_WR,
    ST_SRCH_RD,
    ST_SRCH_EVAL,
    ST_FAIL_FILL,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/core/bitmap_frame_allocator.sv =====
// First-fit allocator over 4 KiB physical frames with a used/free bitmap.
// Input words arrive on s_axis: tuser carries the mode (mark used, mark free,
// allocate), tdata the first and last byte address of a range. Every word
// gives exactly one result word on m_axis: tdata is the allocated frame
// address (zero for range commands) and tuser flags an allocate that found
// no free frame. cfg_we_i/cfg_wdata_i set the number of frames present.
// The bitmap lives in a single-port-write RAM of 64-bit words; one shared
// read-modify-write path under a sequencer does all the work.
// After reset the block clears the bitmap, one word a cycle, all 16384
// words, and only then raises s_axis_tready. A range command reads and
// writes back each bitmap word it touches. An allocate is served from the
// prefetched batch of 20 frames; when the batch is used up, a refill scans
// the bitmap from word 0 and claims the first free frames it finds, and
// after a failed search fills the batch entries left over with frame 0; the
// cost of the scan follows the occupancy of the map.
// One word is in work at a time. The result waits in an output register; a
// stalled receiver holds the sequencer in its final step, while the block
// still accepts the next word once the previous one is finished.
`default_nettype none

module bitmap_frame_allocator (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Configuration: frame_count.
  input  wire                          cfg_we_i,
  input  wire [bfa_pkg::CNT_W-1:0]     cfg_wdata_i,
  // Command stream.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire [bfa_pkg::S_DATA_W-1:0]  s_axis_tdata,  // base_addr, limit_addr
  input  wire [bfa_pkg::S_USER_W-1:0]  s_axis_tuser,  // mode
  // Result stream.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [bfa_pkg::M_DATA_W-1:0] m_axis_tdata,  // frame_addr
  output logic [bfa_pkg::M_USER_W-1:0] m_axis_tuser   // out_of_frames
);

  import bfa_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES = '1;

  state_e state_q, state_d;

  logic [CNT_W-1:0]     frame_count_q;
  logic [MWADDR_W-1:0]  word_q, word_d;
  logic [POS_W-1:0]     fill_q, fill_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic                 pending_q, pending_d;
  logic                 out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]    out_frame_q;
  logic                 out_none_q;
  mode_e                mode_q;
  logic [MAP_IDX_W-1:0] lo_q, hi_q;

  // Bitmap RAM and its read register.
  logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] map_rdata_q;
  logic                 mem_re, mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  // Batch of prefetched frame indices.
  logic [MAP_IDX_W-1:0] batch_q [BATCH];
  logic                 batch_we;
  logic [MAP_IDX_W-1:0] batch_wdata;

  // Incoming word decode.
  logic [IDX_W-1:0]     in_lo, in_hi;
  logic [IDX_W-1:0]     in_hi_clamp;
  logic                 in_empty;
  logic                 accept;
  logic                 need_refill;

  // Search limits from frame_count.
  logic [CNT_W-1:0]     end_frames, end_m1;
  logic                 end_small;
  logic [MWADDR_W-1:0]  last_w;
  logic [WSEL_W-1:0]    last_bit;

  // Shared word datapath.
  logic [WORD_BITS-1:0] range_mask;
  logic [WORD_BITS-1:0] free_bits;
  logic                 found;
  logic [WSEL_W-1:0]    found_bit;
  logic [MAP_IDX_W-1:0] found_frame;
  logic                 at_last, at_hi, fill_last;
  logic                 out_free;
  logic [MAP_IDX_W-1:0] sel_frame;

  // Lowest set bit of a word.
  function automatic logic [WSEL_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [WSEL_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (v[b]) begin
        idx = WSEL_W'(b);
      end
    end
    return idx;
  endfunction

  // Decode of the command on the input.
  assign accept      = s_axis_tvalid && s_axis_tready;
  assign in_lo       = s_axis_tdata[ADDR_W-1:FRAME_SHIFT];
  assign in_hi       = s_axis_tdata[2*ADDR_W-1:ADDR_W+FRAME_SHIFT];
  assign in_hi_clamp = ({1'b0, in_hi} >= (IDX_W + 1)'(MAP_FRAMES)) ?
                       IDX_W'(MAP_FRAMES - 1) : in_hi;
  assign in_empty    = in_lo > in_hi_clamp;
  assign need_refill = pending_q || (pos_q >= POS_W'(BATCH));

  // Search window: frames 1 .. end-1.
  assign end_frames = (frame_count_q < CNT_W'(MAP_FRAMES)) ? frame_count_q
                                                           : CNT_W'(MAP_FRAMES);
  assign end_small  = end_frames <= CNT_W'(1);
  assign end_m1     = end_frames - CNT_W'(1);
  assign last_w     = end_m1[MAP_IDX_W-1:WSEL_W];
  assign last_bit   = end_m1[WSEL_W-1:0];

  // Mask of the range bits inside the current word.
  always_comb begin
    range_mask = ONES;
    if (word_q == lo_q[MAP_IDX_W-1:WSEL_W]) begin
      range_mask = range_mask & (ONES << lo_q[WSEL_W-1:0]);
    end
    if (at_hi) begin
      range_mask = range_mask & (ONES >> (WSEL_W'(WORD_BITS - 1) - hi_q[WSEL_W-1:0]));
    end
  end

  // Free frames of the current word inside the search window.
  always_comb begin
    free_bits = ~map_rdata_q;
    if (word_q == '0) begin
      free_bits[0] = 1'b0;
    end
    if (at_last) begin
      free_bits = free_bits & (ONES >> (WSEL_W'(WORD_BITS - 1) - last_bit));
    end
  end

  assign at_hi       = word_q == hi_q[MAP_IDX_W-1:WSEL_W];
  assign at_last     = word_q == last_w;
  assign found       = free_bits != '0;
  assign found_bit   = lowest_set(free_bits);
  assign found_frame = {word_q, found_bit};
  assign fill_last   = fill_q == POS_W'(BATCH - 1);
  assign out_free    = !out_valid_q || m_axis_tready;
  assign sel_frame   = (mode_q == MODE_ALLOC) ? batch_q[pos_q[BIDX_W-1:0]] : '0;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (word_q == MWADDR_W'(MAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            MODE_USED, MODE_FREE: state_d = in_empty ? ST_DONE : ST_RANGE_RD;
            MODE_ALLOC: begin
              if (!need_refill) begin
                state_d = ST_DONE;
              end else if (end_small) begin
                state_d = ST_FAIL_FILL;
              end else begin
                state_d = ST_SRCH_RD;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RANGE_RD:  state_d = ST_RANGE_WR;
      ST_RANGE_WR:  state_d = at_hi ? ST_DONE : ST_RANGE_RD;
      ST_SRCH_RD:   state_d = ST_SRCH_EVAL;
      ST_SRCH_EVAL: begin
        if (found) begin
          if (fill_last) begin
            state_d = ST_DONE;
          end
        end else if (at_last) begin
          state_d = ST_FAIL_FILL;
        end else begin
          state_d = ST_SRCH_RD;
        end
      end
      ST_FAIL_FILL: begin
        if (fill_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath control and register updates.
  always_comb begin
    s_axis_tready = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = '0;
    batch_we      = 1'b0;
    batch_wdata   = '0;
    word_d        = word_q;
    fill_d        = fill_q;
    pos_d         = pos_q;
    pending_d     = pending_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
        word_d = word_q + MWADDR_W'(1);
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (accept) begin
          word_d = in_lo[MAP_IDX_W-1:WSEL_W];
          fill_d = '0;
          if (s_axis_tuser == MODE_ALLOC) begin
            word_d = '0;
          end
        end
      end
      ST_RANGE_RD, ST_SRCH_RD: begin
        mem_re = 1'b1;
      end
      ST_RANGE_WR: begin
        mem_we    = 1'b1;
        mem_wdata = (mode_q == MODE_USED) ? (map_rdata_q | range_mask)
                                          : (map_rdata_q & ~range_mask);
        word_d    = word_q + MWADDR_W'(1);
      end
      ST_SRCH_EVAL: begin
        if (found) begin
          // Claim the frame; the read register keeps the updated word.
          mem_we      = 1'b1;
          mem_wdata   = map_rdata_q | (WORD_BITS'(1) << found_bit);
          batch_we    = 1'b1;
          batch_wdata = found_frame;
          fill_d      = fill_q + POS_W'(1);
          if (fill_last) begin
            pos_d     = '0;
            pending_d = 1'b0;
          end
        end else begin
          word_d = word_q + MWADDR_W'(1);
        end
      end
      ST_FAIL_FILL: begin
        batch_we = 1'b1;
        fill_d   = fill_q + POS_W'(1);
        if (fill_last) begin
          pos_d     = '0;
          pending_d = 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (mode_q == MODE_ALLOC) begin
            pos_d = pos_q + POS_W'(1);
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q;
      end
    endcase
  end

  // Bitmap RAM: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[word_q] <= mem_wdata;
    end
    if (mem_re) begin
      map_rdata_q <= map_mem[word_q];
    end else if (mem_we) begin
      map_rdata_q <= mem_wdata;
    end
  end

  // Batch store.
  always_ff @(posedge clk_i) begin
    if (batch_we) begin
      batch_q[fill_q[BIDX_W-1:0]] <= batch_wdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      frame_count_q <= CNT_W'(CNT_RESET);
      word_q        <= '0;
      fill_q        <= '0;
      pos_q         <= '0;
      pending_q     <= 1'b1;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_q      <= word_d;
      fill_q      <= fill_d;
      pos_q       <= pos_d;
      pending_q   <= pending_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        frame_count_q <= cfg_wdata_i;
      end
    end
  end

  // Command and result payload; the result stays put while it waits.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(s_axis_tuser);
      lo_q   <= in_lo[MAP_IDX_W-1:0];
      hi_q   <= in_hi_clamp[MAP_IDX_W-1:0];
    end
    if (state_q == ST_DONE && out_free) begin
      out_frame_q <= ADDR_W'(sel_frame) << FRAME_SHIFT;
      out_none_q  <= (mode_q == MODE_ALLOC) && (sel_frame == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_frame_q;
  assign m_axis_tuser  = out_none_q;

endmodule

`default_nettype wire
